/* src/qltt_pkg.sv */
// Shared types, constants and helpers for the Q-learning timeslice tuner.
// No dependencies; used by every module of the block but qltt_ram.
package qltt_pkg;

  // Default geometry
  localparam int ENTRIES_DEF = 128;
  localparam int Q_WIDTH_DEF = 20;

  // Q table shape per task: 4 states x 3 actions
  localparam int NSTATES  = 4;
  localparam int NACTIONS = 3;
  localparam int QPER     = NSTATES * NACTIONS;

  // Register indexes on the config port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IPC_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IPC_MEDIUM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_INIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_FLOOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_CEIL  = 3'd7;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [8:0]  LEARN_RATE_RST  = 9'd26;
  localparam logic [8:0]  DISCOUNT_RST    = 9'd230;
  localparam logic [15:0] FAULT_LIM_RST   = 16'd100;
  localparam logic [15:0] IPC_HIGH_RST    = 16'd500;
  localparam logic [15:0] IPC_MEDIUM_RST  = 16'd50;
  localparam logic [5:0]  SLICE_INIT_RST  = 6'd10;
  localparam logic [5:0]  SLICE_FLOOR_RST = 6'd2;
  localparam logic [5:0]  SLICE_CEIL_RST  = 6'd50;

  // Workload states
  localparam logic [1:0] ST_CALM   = 2'd0;
  localparam logic [1:0] ST_IPC_MD = 2'd1;
  localparam logic [1:0] ST_IPC_HI = 2'd2;
  localparam logic [1:0] ST_FAULTY = 2'd3;

  // Actions
  localparam logic [1:0] ACT_DEC  = 2'd0;
  localparam logic [1:0] ACT_HOLD = 2'd1;
  localparam logic [1:0] ACT_INC  = 2'd2;

  // Reward constants
  localparam logic [18:0] REWARD_BASE = 19'd100;
  localparam logic [18:0] PEN_CLAMP   = 19'd200;
  localparam logic signed [7:0] REWARD_MIN = -8'sd100;
  localparam logic [5:0] SLICE_STEP = 6'd2;

  typedef struct packed {
    logic [8:0]  learn_rate;
    logic [8:0]  discount;
    logic [15:0] fault_limit;
    logic [15:0] ipc_high_limit;
    logic [15:0] ipc_medium_limit;
    logic [5:0]  slice_initial;
    logic [5:0]  slice_floor;
    logic [5:0]  slice_ceiling;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic              empty;
    logic [31:0]       id;
    logic [1:0]        ns;
    logic signed [7:0] reward;
  } work_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SCAN0, B_SCAN, B_ALLOC, B_CLEAR, B_INFO,
    B_Q1, B_Q2, B_Q3, B_Q4, B_MUL1, B_MUL2, B_MUL3, B_MUL4, B_WB, B_STEP
  } back_state_t;

  // Offset of Q(state, action) inside one task's row
  function automatic logic [3:0] q_off(input logic [1:0] st, input logic [1:0] act);
    q_off = {1'b0, st, 1'b0} + {2'b00, st} + {2'b00, act};
  endfunction

endpackage

/* src/qltt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qltt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/qltt_front.sv */
// Front end: accepts input transfers, computes the reward and the new state.
// Depends on qltt_pkg.
module qltt_front (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [127:0]       s_tdata,
  input  logic               s_tuser,
  input  qltt_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               push,
  output qltt_pkg::work_t    item
);

  localparam logic [8:0] REWARD_BASE_9 = qltt_pkg::REWARD_BASE[8:0];

  logic [31:0] task_id;
  logic [15:0] stall_count;
  logic [15:0] latency_ms;
  logic [31:0] fault_count;
  logic [31:0] ipc_count;
  logic [18:0] penalty;
  logic [8:0]  reward_raw;

  assign task_id     = s_tdata[31:0];
  assign stall_count = s_tdata[47:32];
  assign latency_ms  = s_tdata[63:48];
  assign fault_count = s_tdata[95:64];
  assign ipc_count   = s_tdata[127:96];

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // penalty = 2*stall + 5*latency, reward clamped at the low end
  assign penalty    = {2'b00, stall_count, 1'b0} + {1'b0, latency_ms, 2'b00}
                    + {3'b000, latency_ms};
  assign reward_raw = REWARD_BASE_9 - {1'b0, penalty[7:0]};

  always_comb begin
    item.empty = s_tuser;
    item.id    = task_id;
    if (penalty >= qltt_pkg::PEN_CLAMP) begin
      item.reward = qltt_pkg::REWARD_MIN;
    end else begin
      item.reward = $signed(reward_raw[7:0]);
    end
    // state classification, faults first
    priority if (fault_count > {16'b0, cfg.fault_limit}) begin
      item.ns = qltt_pkg::ST_FAULTY;
    end else if (ipc_count > {16'b0, cfg.ipc_high_limit}) begin
      item.ns = qltt_pkg::ST_IPC_HI;
    end else if (ipc_count > {16'b0, cfg.ipc_medium_limit}) begin
      item.ns = qltt_pkg::ST_IPC_MD;
    end else begin
      item.ns = qltt_pkg::ST_CALM;
    end
  end

endmodule

/* src/qltt_fifo.sv */
// Two-entry queue between front and back end.
// Depends on qltt_pkg.
module qltt_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qltt_pkg::work_t din,
  input  logic            pop,
  output qltt_pkg::work_t dout,
  output logic            full,
  output logic            empty
);

  qltt_pkg::work_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/qltt_back.sv */
// Back end: tag search, entry allocation, Q update, action pick, slice step.
// Depends on qltt_pkg and qltt_ram; holds the output register.
module qltt_back #(
  parameter int ENTRIES = qltt_pkg::ENTRIES_DEF,
  parameter int Q_WIDTH = qltt_pkg::Q_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  qltt_pkg::cfg_t  cfg,
  input  qltt_pkg::work_t head,
  input  logic            q_empty,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [39:0]     m_tdata,
  output logic            m_tuser
);

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QD  = ENTRIES * qltt_pkg::QPER;
  localparam int QAW = $clog2(QD);
  localparam int TW  = Q_WIDTH + 6;
  localparam int DW  = TW + 1;
  localparam int PW  = DW + 10;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic signed [PW-1:0] QHI = {{(PW-Q_WIDTH+1){1'b0}}, {(Q_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] QLO = ~QHI;

  qltt_pkg::back_state_t state, state_next;

  // item under work
  logic [31:0]       w_id;
  logic [1:0]        w_ns;
  logic signed [7:0] w_reward;

  // search
  logic [ENTRIES-1:0] valid;
  logic [IW-1:0]      scan_idx;
  logic               have_free;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      e;
  logic [3:0]         clr_k;
  logic               tag_hit;
  logic               slot_free;

  // entry info and Q working set
  logic [5:0]                sl;
  logic [1:0]                ps;
  logic [1:0]                pa;
  logic signed [Q_WIDTH-1:0] qa [3];
  logic signed [Q_WIDTH-1:0] oldq;
  logic signed [Q_WIDTH-1:0] maxq;
  logic signed [Q_WIDTH+9:0] prod1;
  logic signed [DW-1:0]      diff;
  logic signed [PW-1:0]      prod2;
  logic signed [Q_WIDTH-1:0] newq;

  // RAM ports
  logic          tag_we;
  logic [IW-1:0] tag_raddr;
  logic [31:0]   tag_rdata;
  logic          info_we;
  logic [9:0]    info_wdata;
  logic [9:0]    info_rdata;
  logic          q_we;
  logic [QAW-1:0] q_waddr;
  logic [Q_WIDTH-1:0] q_wdata;
  logic [QAW-1:0] q_raddr;
  logic [Q_WIDTH-1:0] q_rdata;
  logic [QAW-1:0] qbase;
  logic          load_out;

  // output register
  logic        out_valid;
  logic        out_empty;
  logic [31:0] out_id;
  logic [5:0]  out_slice;

  assign slot_free = !out_valid || m_tready;
  assign tag_hit   = valid[scan_idx] && (tag_rdata == w_id);
  assign qbase     = QAW'({e, 3'b000}) + QAW'({e, 2'b00});

  qltt_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_tags (
    .clk(clk), .we(tag_we), .waddr(e), .wdata(w_id),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  // info word: slice, previous state, previous action
  qltt_ram #(.WIDTH(10), .DEPTH(ENTRIES)) u_info (
    .clk(clk), .we(info_we), .waddr(e), .wdata(info_wdata),
    .raddr(e), .rdata(info_rdata)
  );

  qltt_ram #(.WIDTH(Q_WIDTH), .DEPTH(QD)) u_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // best action over the three registered Q-values, ties keep the earlier pick
  logic [1:0]                best_act;
  logic signed [Q_WIDTH-1:0] best_q;
  always_comb begin
    best_act = qltt_pkg::ACT_HOLD;
    best_q   = qa[1];
    if (qa[0] > best_q) begin
      best_act = qltt_pkg::ACT_DEC;
      best_q   = qa[0];
    end
    if (qa[2] > best_q) begin
      best_act = qltt_pkg::ACT_INC;
      best_q   = qa[2];
    end
  end

  // slice step for the chosen action
  logic [5:0] sl_new;
  always_comb begin
    sl_new = sl;
    if (best_act == qltt_pkg::ACT_DEC && sl > cfg.slice_floor) begin
      sl_new = (sl < qltt_pkg::SLICE_STEP) ? 6'd0 : sl - qltt_pkg::SLICE_STEP;
    end
    if (best_act == qltt_pkg::ACT_INC && sl < cfg.slice_ceiling) begin
      sl_new = (sl > 6'd61) ? 6'd63 : sl + qltt_pkg::SLICE_STEP;
    end
  end

  // update arithmetic, at most one product per stage
  logic signed [Q_WIDTH+9:0] rnd1_t;
  logic signed [TW-1:0]      rnd1;
  logic signed [TW-1:0]      rew_ext;
  logic signed [TW-1:0]      target;
  logic signed [PW-1:0]      rnd2_t;
  logic signed [PW-1:0]      newfull;
  logic signed [Q_WIDTH-1:0] newq_next;
  always_comb begin
    rnd1_t  = prod1 + (Q_WIDTH+10)'(128);
    rnd1    = TW'(rnd1_t >>> 8);
    rew_ext = TW'(w_reward);
    target  = $signed({rew_ext[TW-9:0], 8'b0}) + rnd1;
    rnd2_t  = prod2 + PW'(128);
    newfull = (rnd2_t >>> 8) + PW'(oldq);
    if (newfull > QHI) begin
      newq_next = Q_WIDTH'(QHI);
    end else if (newfull < QLO) begin
      newq_next = Q_WIDTH'(QLO);
    end else begin
      newq_next = Q_WIDTH'(newfull);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      qltt_pkg::B_IDLE: begin
        if (!q_empty && !head.empty) state_next = qltt_pkg::B_SCAN0;
      end
      qltt_pkg::B_SCAN0: state_next = qltt_pkg::B_SCAN;
      qltt_pkg::B_SCAN: begin
        if (tag_hit)                state_next = qltt_pkg::B_INFO;
        else if (scan_idx == LAST)  state_next = qltt_pkg::B_ALLOC;
      end
      qltt_pkg::B_ALLOC: state_next = qltt_pkg::B_CLEAR;
      qltt_pkg::B_CLEAR: begin
        if (clr_k == 4'(qltt_pkg::QPER - 1)) state_next = qltt_pkg::B_INFO;
      end
      qltt_pkg::B_INFO: state_next = qltt_pkg::B_Q1;
      qltt_pkg::B_Q1:   state_next = qltt_pkg::B_Q2;
      qltt_pkg::B_Q2:   state_next = qltt_pkg::B_Q3;
      qltt_pkg::B_Q3:   state_next = qltt_pkg::B_Q4;
      qltt_pkg::B_Q4:   state_next = qltt_pkg::B_MUL1;
      qltt_pkg::B_MUL1: state_next = qltt_pkg::B_MUL2;
      qltt_pkg::B_MUL2: state_next = qltt_pkg::B_MUL3;
      qltt_pkg::B_MUL3: state_next = qltt_pkg::B_MUL4;
      qltt_pkg::B_MUL4: state_next = qltt_pkg::B_WB;
      qltt_pkg::B_WB:   state_next = qltt_pkg::B_STEP;
      qltt_pkg::B_STEP: begin
        if (slot_free) state_next = qltt_pkg::B_IDLE;
      end
      default: state_next = qltt_pkg::B_IDLE;
    endcase
  end

  // control outputs: RAM ports, queue pop, output load
  always_comb begin
    pop        = 1'b0;
    load_out   = 1'b0;
    tag_we     = 1'b0;
    tag_raddr  = '0;
    info_we    = 1'b0;
    info_wdata = {cfg.slice_initial, qltt_pkg::ST_CALM, qltt_pkg::ACT_DEC};
    q_we       = 1'b0;
    q_waddr    = qbase + QAW'(clr_k);
    q_wdata    = '0;
    q_raddr    = qbase + QAW'(qltt_pkg::q_off(w_ns, 2'd0));
    unique case (state)
      qltt_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (head.empty) begin
            pop      = slot_free;
            load_out = slot_free;
          end else begin
            pop = 1'b1;
          end
        end
      end
      qltt_pkg::B_SCAN: begin
        tag_raddr = (scan_idx == LAST) ? '0 : scan_idx + 1'b1;
      end
      qltt_pkg::B_ALLOC: begin
        tag_we  = 1'b1;
        info_we = 1'b1;
      end
      qltt_pkg::B_CLEAR: q_we = 1'b1;
      qltt_pkg::B_Q1: q_raddr = qbase + QAW'(qltt_pkg::q_off(w_ns, 2'd1));
      qltt_pkg::B_Q2: q_raddr = qbase + QAW'(qltt_pkg::q_off(w_ns, 2'd2));
      qltt_pkg::B_Q3: q_raddr = qbase + QAW'(qltt_pkg::q_off(ps, pa));
      qltt_pkg::B_WB: begin
        q_we    = 1'b1;
        q_waddr = qbase + QAW'(qltt_pkg::q_off(ps, pa));
        q_wdata = newq;
      end
      qltt_pkg::B_STEP: begin
        info_we    = slot_free;
        info_wdata = {sl_new, w_ns, best_act};
        load_out   = slot_free;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qltt_pkg::B_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == qltt_pkg::B_ALLOC) valid[e] <= 1'b1;
      if (load_out)      out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      qltt_pkg::B_IDLE: begin
        w_id     <= head.id;
        w_ns     <= head.ns;
        w_reward <= head.reward;
      end
      qltt_pkg::B_SCAN0: begin
        scan_idx  <= '0;
        have_free <= 1'b0;
      end
      qltt_pkg::B_SCAN: begin
        if (tag_hit) begin
          e <= scan_idx;
        end else begin
          if (!valid[scan_idx] && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= scan_idx;
          end
          if (scan_idx == LAST) begin
            priority if (have_free)    e <= free_idx;
            else if (!valid[scan_idx]) e <= scan_idx;
            else                       e <= '0;
          end
          scan_idx <= scan_idx + 1'b1;
        end
      end
      qltt_pkg::B_ALLOC: clr_k <= '0;
      qltt_pkg::B_CLEAR: clr_k <= clr_k + 4'd1;
      qltt_pkg::B_Q1: begin
        sl    <= info_rdata[9:4];
        ps    <= info_rdata[3:2];
        // actions run 0..2; a stray code maps to the last action
        pa    <= (info_rdata[1:0] == 2'd3) ? qltt_pkg::ACT_INC : info_rdata[1:0];
        qa[0] <= q_rdata;
      end
      qltt_pkg::B_Q2: qa[1] <= q_rdata;
      qltt_pkg::B_Q3: qa[2] <= q_rdata;
      qltt_pkg::B_Q4: begin
        oldq <= q_rdata;
        maxq <= best_q;
      end
      qltt_pkg::B_MUL1: prod1 <= $signed({1'b0, cfg.discount}) * maxq;
      qltt_pkg::B_MUL2: diff  <= DW'(target) - DW'(oldq);
      qltt_pkg::B_MUL3: prod2 <= $signed({1'b0, cfg.learn_rate}) * diff;
      qltt_pkg::B_MUL4: newq  <= newq_next;
      qltt_pkg::B_WB: begin
        // if the previous state is the new state, the written value is visible to the action pick
        if (ps == w_ns) qa[pa] <= newq;
      end
      default: ;
    endcase
    if (load_out) begin
      out_empty <= (state == qltt_pkg::B_IDLE);
      out_id    <= (state == qltt_pkg::B_IDLE) ? 32'hFFFF_FFFF : w_id;
      out_slice <= (state == qltt_pkg::B_IDLE) ? 6'd0 : sl_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_empty;
  assign m_tdata  = {2'b00, out_slice, out_id};

endmodule

/* src/q_learning_timeslice_tuner_top.sv */
// A hit at entry i is found once the tag search reaches entry i; a miss
// scans all ENTRIES tags, then allocates an entry and clears 12 Q-values.
// The back end takes one item at a time, searched one tag per cycle; the
// front queue holds two more. Empty-queue items are answered from idle
// once the output slot is free. Reset (rst, synchronous) clears control
// state, valid bits and restores register defaults; no clearing pass needed.
module q_learning_timeslice_tuner_top #(
  parameter int ENTRIES = qltt_pkg::ENTRIES_DEF,
  parameter int Q_WIDTH = qltt_pkg::Q_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // task_id[31:0], stall_count[47:32], latency_ms[63:48],
  // fault_count[95:64], ipc_count[127:96]
  input  logic [127:0] s_tdata,
  // queue_empty
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // picked_id[31:0], slice_ms[37:32], zero pad [39:38]
  output logic [39:0]  m_tdata,
  // no_task
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [qltt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qltt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  qltt_pkg::cfg_t  cfg;
  qltt_pkg::work_t f_item;
  qltt_pkg::work_t q_head;
  logic            f_push;
  logic            q_full;
  logic            q_empty;
  logic            b_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learn_rate       <= qltt_pkg::LEARN_RATE_RST;
      cfg.discount         <= qltt_pkg::DISCOUNT_RST;
      cfg.fault_limit      <= qltt_pkg::FAULT_LIM_RST;
      cfg.ipc_high_limit   <= qltt_pkg::IPC_HIGH_RST;
      cfg.ipc_medium_limit <= qltt_pkg::IPC_MEDIUM_RST;
      cfg.slice_initial    <= qltt_pkg::SLICE_INIT_RST;
      cfg.slice_floor      <= qltt_pkg::SLICE_FLOOR_RST;
      cfg.slice_ceiling    <= qltt_pkg::SLICE_CEIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qltt_pkg::CFG_LEARN_RATE:  cfg.learn_rate       <= cfg_wdata[8:0];
        qltt_pkg::CFG_DISCOUNT:    cfg.discount         <= cfg_wdata[8:0];
        qltt_pkg::CFG_FAULT_LIM:   cfg.fault_limit      <= cfg_wdata;
        qltt_pkg::CFG_IPC_HIGH:    cfg.ipc_high_limit   <= cfg_wdata;
        qltt_pkg::CFG_IPC_MEDIUM:  cfg.ipc_medium_limit <= cfg_wdata;
        qltt_pkg::CFG_SLICE_INIT:  cfg.slice_initial    <= cfg_wdata[5:0];
        qltt_pkg::CFG_SLICE_FLOOR: cfg.slice_floor      <= cfg_wdata[5:0];
        qltt_pkg::CFG_SLICE_CEIL:  cfg.slice_ceiling    <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  qltt_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg(cfg), .q_full(q_full), .push(f_push), .item(f_item)
  );

  qltt_fifo u_fifo (
    .clk(clk), .rst(rst), .push(f_push), .din(f_item), .pop(b_pop),
    .dout(q_head), .full(q_full), .empty(q_empty)
  );

  qltt_back #(.ENTRIES(ENTRIES), .Q_WIDTH(Q_WIDTH)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(q_head), .q_empty(q_empty),
    .pop(b_pop), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

/* tb/q_learning_timeslice_tuner_top_test.sv */
// Self-checking testbench for q_learning_timeslice_tuner_top: a behavioral
// timeslice predictor, directed and random stream traffic, register sweeps.
// Depends on qltt_pkg and the top module only.
`timescale 1ns / 1ps

module q_learning_timeslice_tuner_top_test;
  import qltt_pkg::*;

  localparam int N_ENT   = ENTRIES_DEF;
  localparam int QW      = Q_WIDTH_DEF;
  localparam int HOLD_CY = 400;

  typedef struct {
    logic        empty;
    logic [31:0] id;
    logic [15:0] stalls;
    logic [15:0] lat;
    logic [31:0] faults;
    logic [31:0] ipc;
  } sched_item_t;

  typedef struct {
    logic        no_task;
    logic [31:0] id;
    logic [5:0]  slice;
  } pick_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  q_learning_timeslice_tuner_top dut (.*);

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the tuner registers and task table
  logic [8:0]  alpha_q, gamma_q;
  logic [15:0] fault_lim_q, ipc_hi_q, ipc_md_q;
  logic [5:0]  sl_init_q, sl_floor_q, sl_ceil_q;
  logic [31:0] tag_tab [N_ENT];
  bit          valid_tab [N_ENT];
  longint      q_tab [N_ENT][QPER];
  logic [1:0]  last_st [N_ENT];
  logic [1:0]  last_act [N_ENT];
  logic [5:0]  slice_tab [N_ENT];

  pick_t       expected_picks[$];
  int          mismatches = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          holding = 1'b0;
  event        start_hold;
  logic [31:0] id_pool [48];

  function automatic longint rnd8(longint x);
    return (x + 128) >>> 8;
  endfunction

  // Start at hold, take any strictly larger Q in action order
  function automatic logic [1:0] best_act(int e, logic [1:0] st);
    logic [1:0] best;
    longint mx;
    best = ACT_HOLD;
    mx = q_tab[e][int'(st) * NACTIONS + 1];
    for (int a = 0; a < NACTIONS; a++)
      if (q_tab[e][int'(st) * NACTIONS + a] > mx) begin
        mx = q_tab[e][int'(st) * NACTIONS + a];
        best = a[1:0];
      end
    return best;
  endfunction

  function automatic pick_t tune_slice(sched_item_t it);
    pick_t r;
    int e, sl;
    bit hit, got_free;
    longint reward, maxq, oldq, target, newq, qhi;
    logic [1:0] ns, ps, pa, act;
    e = 0;
    hit = 0;
    got_free = 0;
    if (it.empty) begin
      r.no_task = 1'b1;
      r.id = '1;
      r.slice = '0;
      return r;
    end
    for (int i = 0; i < N_ENT && !hit; i++)
      if (valid_tab[i] && tag_tab[i] == it.id) begin
        e = i;
        hit = 1;
      end
    // miss: first free entry, else entry 0, with a clean Q row
    if (!hit) begin
      for (int i = 0; i < N_ENT && !got_free; i++)
        if (!valid_tab[i]) begin
          e = i;
          got_free = 1;
        end
      if (!got_free) e = 0;
      tag_tab[e] = it.id;
      valid_tab[e] = 1;
      slice_tab[e] = sl_init_q;
      last_st[e] = ST_CALM;
      last_act[e] = ACT_DEC;
      for (int k = 0; k < QPER; k++) q_tab[e][k] = 0;
    end
    reward = 100 - 2 * longint'(it.stalls) - 5 * longint'(it.lat);
    if (reward < -100) reward = -100;
    if (it.faults > fault_lim_q) ns = ST_FAULTY;
    else if (it.ipc > ipc_hi_q) ns = ST_IPC_HI;
    else if (it.ipc > ipc_md_q) ns = ST_IPC_MD;
    else ns = ST_CALM;
    ps = last_st[e];
    pa = last_act[e];
    maxq = q_tab[e][int'(ns) * NACTIONS + best_act(e, ns)];
    oldq = q_tab[e][int'(ps) * NACTIONS + pa];
    target = reward * 256 + rnd8(longint'(gamma_q) * maxq);
    newq = oldq + rnd8(longint'(alpha_q) * (target - oldq));
    qhi = (longint'(1) <<< (QW - 1)) - 1;
    if (newq > qhi) newq = qhi;
    if (newq < -qhi - 1) newq = -qhi - 1;
    q_tab[e][int'(ps) * NACTIONS + pa] = newq;
    act = best_act(e, ns);
    sl = slice_tab[e];
    if (act == ACT_DEC && sl > sl_floor_q) begin
      sl -= 2;
      if (sl < 0) sl = 0;
    end
    if (act == ACT_INC && sl < sl_ceil_q) begin
      sl += 2;
      if (sl > 63) sl = 63;
    end
    slice_tab[e] = sl[5:0];
    last_st[e] = ns;
    last_act[e] = act;
    r.no_task = 1'b0;
    r.id = it.id;
    r.slice = sl[5:0];
    return r;
  endfunction

  // Offer one item at a falling edge, predict on the accepting rising edge
  task automatic send_item(sched_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = it.empty;
    s_tdata = {it.ipc, it.faults, it.lat, it.stalls, it.id};
    do @(posedge clk); while (!s_tready);
    expected_picks.push_back(tune_slice(it));
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    wait (expected_picks.size() == 0);
    repeat (N_ENT + 60) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_LEARN_RATE:  alpha_q = val[8:0];
      CFG_DISCOUNT:    gamma_q = val[8:0];
      CFG_FAULT_LIM:   fault_lim_q = val;
      CFG_IPC_HIGH:    ipc_hi_q = val;
      CFG_IPC_MEDIUM:  ipc_md_q = val;
      CFG_SLICE_INIT:  sl_init_q = val[5:0];
      CFG_SLICE_FLOOR: sl_floor_q = val[5:0];
      default:         sl_ceil_q = val[5:0];
    endcase
  endtask

  task automatic set_all(int lr, int dc, int fl, int ih, int im, int si, int sf, int sc);
    write_reg(CFG_LEARN_RATE, 16'(lr));
    write_reg(CFG_DISCOUNT, 16'(dc));
    write_reg(CFG_FAULT_LIM, 16'(fl));
    write_reg(CFG_IPC_HIGH, 16'(ih));
    write_reg(CFG_IPC_MEDIUM, 16'(im));
    write_reg(CFG_SLICE_INIT, 16'(si));
    write_reg(CFG_SLICE_FLOOR, 16'(sf));
    write_reg(CFG_SLICE_CEIL, 16'(sc));
  endtask

  function automatic sched_item_t mk(logic empty, logic [31:0] id, logic [15:0] st,
                                     logic [15:0] lat, logic [31:0] f, logic [31:0] ipc);
    sched_item_t it;
    it.empty = empty;
    it.id = id;
    it.stalls = st;
    it.lat = lat;
    it.faults = f;
    it.ipc = ipc;
    return it;
  endfunction

  // Mostly known tasks and realistic counts, sometimes raw 32-bit noise
  function automatic sched_item_t rand_item();
    sched_item_t it;
    int pick;
    it.empty = ($urandom_range(0, 15) == 0);
    it.id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 47)];
    pick = $urandom_range(0, 9);
    it.stalls = 16'((pick == 0) ? $urandom() : $urandom_range(0, 40));
    it.lat = 16'((pick == 1) ? $urandom() : $urandom_range(0, 25));
    it.faults = (pick == 2) ? $urandom() : $urandom_range(0, 2 * fault_lim_q + 2);
    it.ipc = (pick == 3) ? $urandom() : $urandom_range(0, 2 * ipc_hi_q + 2);
    return it;
  endfunction

  task automatic test_directed();
    send_item(mk(1, 32'h0, 0, 0, 0, 0));
    send_item(mk(1, '1, '1, '1, '1, '1));
    send_item(mk(0, 32'h0, 0, 0, 0, 0));
    send_item(mk(0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, '1, '1));
    // same task again: hit path, each state in turn
    send_item(mk(0, 32'h0, 0, 0, 0, 0));
    send_item(mk(0, 32'h0, 0, 0, 0, 51));
    send_item(mk(0, 32'h0, 0, 0, 0, 501));
    send_item(mk(0, 32'h0, 0, 0, 101, 0));
    send_item(mk(0, 32'h0, 40, 4, 100, 500));
    send_item(mk(0, 32'h0, 16'hFFFF, 0, 0, 50));
    send_item(mk(0, 32'h0, 0, 16'hFFFF, 0, 0));
    send_item(mk(0, 32'hA5A5_5A5A, 10, 0, 0, 0));
    for (int i = 0; i < 10; i++)
      send_item(mk(0, 32'hA5A5_5A5A, 0, 0, 0, (i % 3) * 300));
  endtask

  // More distinct tasks than entries: the table fills and entry 0 is reused
  task automatic test_table_overflow();
    for (int i = 0; i < N_ENT + 12; i++)
      send_item(mk(0, 32'h1000_0000 + i, 16'($urandom_range(0, 50)), 0, 0, 0));
    for (int i = 0; i < 8; i++) begin
      send_item(mk(0, 32'h1000_0000 + N_ENT + 11, 0, 0, 0, 0));
      send_item(mk(0, 32'h1000_0000 + 5 + i, 0, 0, 200, 0));
    end
  endtask

  // Extreme register settings, incl. slice clamps at 0 and 63
  task automatic test_reg_extremes();
    set_all(256, 256, 0, 0, 0, 1, 0, 63);
    for (int i = 0; i < 20; i++) send_item(rand_item());
    set_all(0, 0, 65535, 65535, 65535, 62, 50, 63);
    for (int i = 0; i < 20; i++) send_item(rand_item());
    set_all(256, 0, 100, 500, 50, 0, 0, 2);
    for (int i = 0; i < 20; i++) send_item(rand_item());
    set_all(128, 256, 30, 300, 20, 63, 63, 0);
    for (int i = 0; i < 20; i++) send_item(rand_item());
  endtask

  task automatic test_random(int n, bit with_hold);
    set_all($urandom_range(8, 256), $urandom_range(0, 256), $urandom_range(0, 300),
            $urandom_range(100, 900), $urandom_range(0, 100), $urandom_range(2, 50),
            $urandom_range(0, 20), $urandom_range(30, 60));
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 2) -> start_hold;
      send_item(rand_item());
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked
  always @(negedge clk)
    m_tready = holding ? 1'b0 : ($urandom_range(0, 99) >= recv_idle);

  initial forever begin
    @(start_hold);
    holding = 1'b1;
    repeat (HOLD_CY) @(negedge clk);
    holding = 1'b0;
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    pick_t exp_p;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result transfer: id %h", m_tdata[31:0]);
        mismatches++;
      end else begin
        exp_p = expected_picks.pop_front();
        if (m_tuser !== exp_p.no_task) begin
          $error("no_task: expected %0d, got %0d", exp_p.no_task, m_tuser);
          mismatches++;
        end
        if (m_tdata[31:0] !== exp_p.id) begin
          $error("picked_id: expected %h, got %h", exp_p.id, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[37:32] !== exp_p.slice) begin
          $error("slice_ms: expected %0d, got %0d", exp_p.slice, m_tdata[37:32]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    alpha_q = LEARN_RATE_RST;
    gamma_q = DISCOUNT_RST;
    fault_lim_q = FAULT_LIM_RST;
    ipc_hi_q = IPC_HIGH_RST;
    ipc_md_q = IPC_MEDIUM_RST;
    sl_init_q = SLICE_INIT_RST;
    sl_floor_q = SLICE_FLOOR_RST;
    sl_ceil_q = SLICE_CEIL_RST;
    for (int i = 0; i < N_ENT; i++) begin
      valid_tab[i] = 0;
      last_st[i] = ST_CALM;
      last_act[i] = ACT_DEC;
      for (int k = 0; k < QPER; k++) q_tab[i][k] = 0;
    end
    for (int i = 0; i < 48; i++) id_pool[i] = $urandom();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_table_overflow();
    test_reg_extremes();
    send_idle = 32;
    recv_idle = 87;
    test_random(250, 0);
    send_idle = 87;
    recv_idle = 32;
    test_random(250, 0);
    send_idle = 0;
    recv_idle = 0;
    test_random(340, 1);
    drain();

    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* q_learning_timeslice_tuner_top.f */
src/qltt_pkg.sv
src/qltt_ram.sv
src/qltt_front.sv
src/qltt_fifo.sv
src/qltt_back.sv
src/q_learning_timeslice_tuner_top.sv
tb/q_learning_timeslice_tuner_top_test.sv
